[src/fqs_pkg.sv]
// fqs_pkg: shared types, constants and the element drop function
// of the feature qualifier selector
// no dependencies
package fqs_pkg;

	localparam int FLAG_W     = 5;
	localparam int LEN_W      = 7;
	localparam int VAL_W      = 32;
	localparam int OUT_IDX_W  = 6;
	localparam int POS_W      = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int MAX_DIM_DEF = 64;

	// qualifier bit positions
	localparam int Q_E = 0;
	localparam int Q_N = 1;
	localparam int Q_D = 2;
	localparam int Q_A = 3;
	localparam int Q_Z = 4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_FLAGS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WANTED_FLAGS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_LENGTH = 2'd2;

	typedef logic signed [POS_W-1:0] lpos_t;
	typedef logic [FLAG_W-1:0] flags_t;

	// block layout of one vector: base start, energy and zeroth positions per block
	typedef struct packed {
		lpos_t  pb0, pb1, pb2;
		lpos_t  pe0, pe1, pe2;
		lpos_t  pz0, pz1, pz2;
		lpos_t  blen;
		flags_t s;
		flags_t d;
	} layout_t;

	typedef struct packed {
		logic   drop;
		flags_t flags;
	} drop_t;

	// layout status handed from the layout unit to the element path
	typedef struct packed {
		layout_t           layout;
		logic              err;
		flags_t            flags;
		logic [LEN_W-1:0]  rlen;
	} status_t;

	function automatic logic fqs_in_span(lpos_t pos, lpos_t start, lpos_t n);
		logic signed [POS_W:0] lim;
		lim = $signed({start[POS_W-1], start}) + $signed({n[POS_W-1], n});
		return ($signed(pos) >= $signed(start)) &&
			($signed({pos[POS_W-1], pos}) < lim);
	endfunction

	function automatic drop_t fqs_drop(layout_t ly, lpos_t pos);
		flags_t del;
		flags_t add;
		flags_t nt;
		logic   m;
		drop_t  r;
		del = ly.s & ~ly.d;
		add = ~ly.s & ly.d;
		nt  = ly.s;
		m   = 1'b0;
		// suppress static energy, or else the static zeroth term
		if (add[Q_N]) begin
			if (ly.s[Q_E]) begin
				m = m | (pos == ly.pe0);
				nt[Q_N] = 1'b1;
			end else if (ly.s[Q_Z]) begin
				m = m | (pos == ly.pz0);
				nt[Q_N] = 1'b1;
			end
		end
		// dropping delta also drops acceleration
		if (del[Q_D]) del[Q_A] = 1'b1;
		if (del[Q_A]) begin
			m = m | fqs_in_span(pos, ly.pb2, ly.blen);
			nt[Q_A] = 1'b0;
		end
		if (del[Q_D]) begin
			m = m | fqs_in_span(pos, ly.pb1, ly.blen);
			nt[Q_D] = 1'b0;
		end
		if (del[Q_E]) begin
			m = m | (pos == ly.pe2) | (pos == ly.pe1);
			if (!nt[Q_N]) m = m | (pos == ly.pe0);
			nt[Q_E] = 1'b0;
			nt[Q_N] = 1'b0;
			del[Q_E] = 1'b0;
			del[Q_N] = 1'b0;
		end
		if (del[Q_Z]) begin
			m = m | (pos == ly.pz2) | (pos == ly.pz1);
			if (!nt[Q_N]) m = m | (pos == ly.pz0);
			nt[Q_Z] = 1'b0;
			nt[Q_N] = 1'b0;
		end
		r.drop  = m;
		r.flags = nt;
		return r;
	endfunction

endpackage

[src/fqs_layout.sv]
// fqs_layout: configuration registers, block layout derivation and the
// result length sweep after each configuration change
// depends on fqs_pkg
module fqs_layout
	import fqs_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [LEN_W-1:0]              cfg_data,
	output logic                          busy,
	output status_t                       status,
	output logic [$clog2(MAX_DIM+1)-1:0]  flen
);

	localparam int CW = $clog2(MAX_DIM + 1);
	localparam int PW = $clog2(MAX_DIM);

	localparam logic [1:0] ST_READY = 2'd0;
	localparam logic [1:0] ST_LOAD  = 2'd1;
	localparam logic [1:0] ST_SWEEP = 2'd2;

	logic [1:0]       state_q;
	flags_t           src_q;
	flags_t           want_q;
	logic [LEN_W-1:0] len_q;

	layout_t          layout_q;
	logic             err_q;
	logic [CW-1:0]    flen_q;
	logic [CW-1:0]    cnt_q;
	logic [PW-1:0]    idx_q;
	logic [LEN_W-1:0] rlen_q;

	layout_t          layout_c;
	logic             err_c;
	logic [CW-1:0]    flen_c;
	logic [7:0]       size_c;
	logic [15:0]      prod_c;
	logic [6:0]       q3_c;
	logic [7:0]       q3x3_c;
	logic [7:0]       per_c;
	logic [1:0]       blocks_c;
	lpos_t            base_c;
	drop_t            sweep_d;
	drop_t            flag_d;
	logic [CW-1:0]    cnt_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q  <= '0;
			want_q <= '0;
			len_q  <= LEN_W'(1);
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_SOURCE_FLAGS:  src_q  <= cfg_data[FLAG_W-1:0];
				CFG_WANTED_FLAGS:  want_q <= cfg_data[FLAG_W-1:0];
				CFG_SOURCE_LENGTH: len_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// layout from the current registers
	always_comb begin
		size_c   = {1'b0, len_q} + {7'd0, src_q[Q_N]};
		blocks_c = 2'd1 + {1'b0, src_q[Q_D]} + {1'b0, src_q[Q_A]};
		// divide by three through the reciprocal, exact for 8-bit values
		prod_c   = 16'(size_c) * 16'd171;
		q3_c     = prod_c[15:9];
		q3x3_c   = {q3_c, 1'b0} + {1'b0, q3_c};
		per_c    = size_c;
		err_c    = (len_q == '0) || (int'(len_q) > MAX_DIM);
		case (blocks_c)
			2'd2: begin
				per_c = {1'b0, size_c[7:1]};
				err_c = err_c | size_c[0];
			end
			2'd3: begin
				per_c = {1'b0, q3_c};
				err_c = err_c | (size_c != q3x3_c);
			end
			default: ;
		endcase
		base_c = lpos_t'(per_c) - lpos_t'(src_q[Q_E]) - lpos_t'(src_q[Q_Z]);
		err_c  = err_c | base_c[POS_W-1];

		layout_c     = '0;
		layout_c.s   = src_q;
		layout_c.d   = want_q;
		if (src_q[Q_E] && src_q[Q_Z]) begin
			layout_c.pz0  = base_c;
			layout_c.pe0  = base_c + lpos_t'(1);
			layout_c.blen = base_c + lpos_t'(2);
		end else if (src_q[Q_E] || src_q[Q_Z]) begin
			layout_c.pz0  = base_c;
			layout_c.pe0  = base_c;
			layout_c.blen = base_c + lpos_t'(1);
		end else begin
			layout_c.blen = base_c;
		end
		layout_c.pb1 = layout_c.blen;
		layout_c.pb2 = layout_c.blen + layout_c.blen;
		layout_c.pe1 = layout_c.pe0 + layout_c.blen;
		layout_c.pe2 = layout_c.pe1 + layout_c.blen;
		layout_c.pz1 = layout_c.pz0 + layout_c.blen;
		layout_c.pz2 = layout_c.pz1 + layout_c.blen;
		// suppressed static energy: vector starts one element early after block 0
		if (src_q[Q_N]) begin
			layout_c.pe0 = '0;
			layout_c.pb1 = layout_c.pb1 - lpos_t'(1);
			layout_c.pb2 = layout_c.pb2 - lpos_t'(1);
			layout_c.pe1 = layout_c.pe1 - lpos_t'(1);
			layout_c.pe2 = layout_c.pe2 - lpos_t'(1);
			layout_c.pz1 = layout_c.pz1 - lpos_t'(1);
			layout_c.pz2 = layout_c.pz2 - lpos_t'(1);
		end

		if (len_q == '0)
			flen_c = CW'(1);
		else if (int'(len_q) > MAX_DIM)
			flen_c = CW'(MAX_DIM);
		else
			flen_c = CW'(len_q);
	end

	assign sweep_d  = fqs_drop(layout_q, lpos_t'(idx_q));
	assign flag_d   = fqs_drop(layout_q, '0);
	assign cnt_next = cnt_q + CW'(!sweep_d.drop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			idx_q   <= '0;
			cnt_q   <= '0;
			rlen_q  <= '0;
		end else if (cfg_write) begin
			state_q <= ST_LOAD;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					idx_q   <= '0;
					cnt_q   <= '0;
					rlen_q  <= '0;
					state_q <= err_c ? ST_READY : ST_SWEEP;
				end
				ST_SWEEP: begin
					cnt_q <= cnt_next;
					if (CW'(idx_q) == flen_q - CW'(1)) begin
						rlen_q  <= LEN_W'(cnt_next);
						state_q <= ST_READY;
					end else begin
						idx_q <= idx_q + PW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			layout_q <= layout_c;
			err_q    <= err_c;
			flen_q   <= flen_c;
		end
	end

	assign busy          = (state_q != ST_READY);
	assign flen          = flen_q;
	assign status.layout = layout_q;
	assign status.err    = err_q;
	assign status.flags  = err_q ? layout_q.s : flag_d.flags;
	assign status.rlen   = err_q ? '0 : rlen_q;

endmodule

[src/fqs_select.sv]
// fqs_select: element path with input register, frame counters,
// keep decision and result register
// depends on fqs_pkg
module fqs_select
	import fqs_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          busy,
	input  status_t                       status,
	input  logic [$clog2(MAX_DIM+1)-1:0]  flen,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [VAL_W-1:0]              element_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          keep,
	output logic [VAL_W-1:0]              kept_value,
	output logic [OUT_IDX_W-1:0]          out_index,
	output logic                          frame_end,
	output flags_t                        result_flags,
	output logic [LEN_W-1:0]              result_length,
	output logic                          format_error
);

	localparam int CW = $clog2(MAX_DIM + 1);
	localparam int PW = $clog2(MAX_DIM);

	logic             valid_s1;
	logic [VAL_W-1:0] value_s1;
	logic             valid_s2;
	logic             keep_s2;
	logic [VAL_W-1:0] value_s2;
	logic [OUT_IDX_W-1:0] index_s2;
	logic             fend_s2;
	flags_t           flags_s2;
	logic [LEN_W-1:0] rlen_s2;
	logic             err_s2;

	logic [PW-1:0]    elem_pos_q;
	logic [CW-1:0]    kept_cnt_q;

	logic             s2_free;
	logic             advance;
	logic             accept;
	logic [PW-1:0]    pos_c;
	logic             keep_c;
	logic             fend_c;
	drop_t            drop_c;

	assign s2_free  = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && s2_free;
	assign in_stall = busy || (valid_s1 && !s2_free);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		if (CW'(elem_pos_q) >= flen)
			pos_c = PW'(flen - CW'(1));
		else
			pos_c = elem_pos_q;
		drop_c = fqs_drop(status.layout, lpos_t'(pos_c));
		keep_c = !status.err && !drop_c.drop;
		fend_c = (CW'(pos_c) == flen - CW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			elem_pos_q <= '0;
			kept_cnt_q <= '0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				valid_s2 <= 1'b1;
			else if (!out_stall)
				valid_s2 <= 1'b0;
			if (advance) begin
				if (fend_c) begin
					elem_pos_q <= '0;
					kept_cnt_q <= '0;
				end else begin
					elem_pos_q <= pos_c + PW'(1);
					kept_cnt_q <= kept_cnt_q + CW'(keep_c);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			value_s1 <= element_value;
		if (advance) begin
			keep_s2  <= keep_c;
			value_s2 <= value_s1;
			index_s2 <= keep_c ? OUT_IDX_W'(kept_cnt_q) : '0;
			fend_s2  <= fend_c;
			flags_s2 <= status.flags;
			rlen_s2  <= status.rlen;
			err_s2   <= status.err;
		end
	end

	assign out_valid     = valid_s2;
	assign keep          = keep_s2;
	assign kept_value    = value_s2;
	assign out_index     = index_s2;
	assign frame_end     = fend_s2;
	assign result_flags  = flags_s2;
	assign result_length = rlen_s2;
	assign format_error  = err_s2;

endmodule

[src/feature_qualifier_selector.sv]
// feature_qualifier_selector: top level, one feature element in and one report out
// an element passes the input and result registers; one element per cycle sustained while
// out_stall is low and the layout unit is not busy; after reset or the last configuration write
// the input stalls while the layout is loaded and every frame position is swept for the kept
// length (no sweep on a format error); reset clears pipeline valids, frame counters and the registers to 0, 0, 1
// depends on fqs_pkg, fqs_layout, fqs_select
module feature_qualifier_selector
	import fqs_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [LEN_W-1:0]      cfg_data,
	// element input channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [VAL_W-1:0]      element_value,
	// result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  keep,
	output logic [VAL_W-1:0]      kept_value,
	output logic [OUT_IDX_W-1:0]  out_index,
	output logic                  frame_end,
	output logic [FLAG_W-1:0]     result_flags,
	output logic [LEN_W-1:0]      result_length,
	output logic                  format_error
);

	localparam int CW = $clog2(MAX_DIM + 1);

	// layout status; the user must not write the configuration while elements are in flight, not enforced here
	status_t       status;
	logic          busy;
	logic [CW-1:0] flen;

	// config registers, layout derivation and kept-length sweep
	fqs_layout #(
		.MAX_DIM (MAX_DIM)
	) u_layout (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.busy      (busy),
		.status    (status),
		.flen      (flen)
	);

	// element path: input register, keep decision, result register
	fqs_select #(
		.MAX_DIM (MAX_DIM)
	) u_select (
		.clk           (clk),
		.arst_n        (arst_n),
		.busy          (busy),
		.status        (status),
		.flen          (flen),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.element_value (element_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.keep          (keep),
		.kept_value    (kept_value),
		.out_index     (out_index),
		.frame_end     (frame_end),
		.result_flags  (result_flags),
		.result_length (result_length),
		.format_error  (format_error)
	);

endmodule
